FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/nbns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NetBIOS name service package
// Shared types, constants and the first-level name encoding function.
// ----------------------------------------------------------------------------
package nbns_pkg;

   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 64;

   localparam logic [CsrIdxW-1:0] CSR_NAME_LOW  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_NAME_HIGH = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_NAME_LEN  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_REPLY_IP  = 3'd3;

   // Request offsets that carry checks or fields.
   localparam logic [5:0] OFF_ID_HI    = 6'd0;
   localparam logic [5:0] OFF_ID_LO    = 6'd1;
   localparam logic [5:0] OFF_FLAGS    = 6'd2;
   localparam logic [5:0] OFF_QD_HI    = 6'd4;
   localparam logic [5:0] OFF_QD_LO    = 6'd5;
   localparam logic [5:0] OFF_NS_HI    = 6'd8;
   localparam logic [5:0] OFF_NS_LO    = 6'd9;
   localparam logic [5:0] OFF_AR_HI    = 6'd10;
   localparam logic [5:0] OFF_AR_LO    = 6'd11;
   localparam logic [5:0] OFF_LABEL    = 6'd12;
   localparam logic [5:0] OFF_NAME_0   = 6'd13;
   localparam logic [5:0] OFF_NAME_31  = 6'd44;
   localparam logic [5:0] OFF_NAME_END = 6'd45;
   localparam logic [5:0] OFF_TYPE_HI  = 6'd46;
   localparam logic [5:0] OFF_TYPE_LO  = 6'd47;
   localparam logic [5:0] OFF_CLASS_HI = 6'd48;
   localparam logic [5:0] OFF_CLASS_LO = 6'd49;
   localparam logic [5:0] OFF_MAX      = 6'd63;

   localparam logic [5:0] RESP_LAST    = 6'd61;

   localparam logic [7:0] FLAGS_CHECK_MASK = 8'hf8;
   localparam logic [7:0] LABEL_LEN        = 8'h20;
   localparam logic [7:0] TYPE_NB          = 8'd32;
   localparam logic [7:0] CLASS_IN         = 8'd1;
   localparam logic [7:0] RESP_FLAGS_HI    = 8'h85;
   localparam logic [7:0] RESP_FLAGS_LO    = 8'h80;
   localparam logic [7:0] RESP_TTL         = 8'd60;
   localparam logic [7:0] RESP_RDLEN       = 8'd6;
   localparam logic [7:0] CHAR_A           = 8'h41;
   localparam logic [7:0] CHAR_SPACE       = 8'h20;

   typedef struct packed {
      logic [15:0] query_id;
      logic [15:0] authority_count;
      logic [15:0] additional_count;
   } nbns_job_type;

   typedef struct packed {
      logic [63:0] name_chars_low;
      logic [55:0] name_chars_high;
      logic [3:0]  name_length;
      logic [31:0] reply_ip;
   } nbns_cfg_type;

   // Encoded name byte at position pos of the 32-byte first-level encoding.
   function automatic logic [7:0] nbns_enc_byte(input nbns_cfg_type cfg,
                                                input logic [4:0] pos);
      logic [3:0] ci;
      logic [7:0] c;
      logic [3:0] nib;
      ci = pos[4:1];
      if (ci == 4'd15) begin
         c = 8'h00;
      end else if (ci >= cfg.name_length) begin
         c = CHAR_SPACE;
      end else if (ci < 4'd8) begin
         c = 8'(cfg.name_chars_low >> {3'd7 - ci[2:0], 3'b000});
      end else begin
         c = 8'(cfg.name_chars_high >> {3'(4'd14 - ci), 3'b000});
      end
      if (c inside {[8'h61:8'h7a]}) begin
         c = c - 8'h20;
      end
      nib = pos[0] ? c[3:0] : c[7:4];
      return CHAR_A + {4'h0, nib};
   endfunction

endpackage

FILE: rtl/nbns_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NetBIOS job queue
// Small queue of accepted queries between the parser and the reply generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nbns_job_fifo
   import nbns_pkg::*;
#(
   parameter int unsigned Depth = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  nbns_job_type push_job,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output nbns_job_type head_job
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   nbns_job_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(Depth), "job count overflow")
   `ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full, "job pushed while queue full")

endmodule

FILE: rtl/nbns_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NetBIOS query parser
// Checks each request byte at its offset and queues a job for passing queries.
// ----------------------------------------------------------------------------
module nbns_parser
   import nbns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  nbns_cfg_type cfg,
   input  logic         beat,
   input  logic [7:0]   payload_byte,
   input  logic         end_of_packet,
   output logic         job_push,
   output nbns_job_type job
);

   logic [5:0]  offset_ff, offset_in;
   logic        ok_ff, ok_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] auth_ff, auth_in;
   logic [15:0] addl_ff, addl_in;
   logic        byte_ok;
   logic [7:0]  exp_name;
   logic [5:0]  name_pos;

   assign name_pos = offset_ff - OFF_NAME_0;
   assign exp_name = nbns_enc_byte(cfg, name_pos[4:0]);

   always_comb begin
      if (offset_ff inside {[OFF_NAME_0:OFF_NAME_31]}) begin
         byte_ok = (payload_byte == exp_name);
      end else begin
         case (offset_ff)
            OFF_FLAGS:    byte_ok = ((payload_byte & FLAGS_CHECK_MASK) == 8'h00);
            OFF_QD_HI:    byte_ok = (payload_byte == 8'h00);
            OFF_QD_LO:    byte_ok = (payload_byte == 8'h01);
            OFF_LABEL:    byte_ok = (payload_byte == LABEL_LEN);
            OFF_NAME_END: byte_ok = (payload_byte == 8'h00);
            OFF_TYPE_HI:  byte_ok = (payload_byte == 8'h00);
            OFF_TYPE_LO:  byte_ok = (payload_byte == TYPE_NB);
            OFF_CLASS_HI: byte_ok = (payload_byte == 8'h00);
            OFF_CLASS_LO: byte_ok = (payload_byte == CLASS_IN);
            default:      byte_ok = 1'b1;
         endcase
      end
   end

   always_comb begin
      id_in   = id_ff;
      auth_in = auth_ff;
      addl_in = addl_ff;
      case (offset_ff)
         OFF_ID_HI: id_in[15:8]   = payload_byte;
         OFF_ID_LO: id_in[7:0]    = payload_byte;
         OFF_NS_HI: auth_in[15:8] = payload_byte;
         OFF_NS_LO: auth_in[7:0]  = payload_byte;
         OFF_AR_HI: addl_in[15:8] = payload_byte;
         OFF_AR_LO: addl_in[7:0]  = payload_byte;
         default: ;
      endcase
   end

   // A query of at least 50 bytes ends on or after the class field.
   assign job_push = beat && end_of_packet && ok_ff && byte_ok && (offset_ff >= OFF_CLASS_LO);
   assign job.query_id         = id_ff;
   assign job.authority_count  = auth_ff;
   assign job.additional_count = addl_ff;

   always_comb begin
      offset_in = offset_ff;
      ok_in     = ok_ff;
      if (beat) begin
         if (end_of_packet) begin
            offset_in = '0;
            ok_in     = 1'b1;
         end else begin
            offset_in = (offset_ff == OFF_MAX) ? offset_ff : offset_ff + 1'b1;
            ok_in     = ok_ff && byte_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         ok_ff     <= 1'b1;
         id_ff     <= '0;
         auth_ff   <= '0;
         addl_ff   <= '0;
      end else if (beat) begin
         offset_ff <= offset_in;
         ok_ff     <= ok_in;
         id_ff     <= id_in;
         auth_ff   <= auth_in;
         addl_ff   <= addl_in;
      end
   end

endmodule

FILE: rtl/nbns_reply_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NetBIOS reply generator
// Streams the 62-byte positive name query response for each queued job.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nbns_reply_gen
   import nbns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  nbns_cfg_type cfg,
   input  logic         job_valid,
   input  nbns_job_type job,
   output logic         job_pop,
   output logic         out_valid,
   output logic [7:0]   out_byte,
   output logic         out_last,
   input  logic         out_take
);

   logic [5:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [7:0] resp_byte;
   logic [7:0] enc;
   logic [5:0] name_pos;
   logic       advance;
   logic       at_last;

   assign name_pos = idx_ff - OFF_NAME_0;
   assign enc      = nbns_enc_byte(cfg, name_pos[4:0]);
   assign at_last  = (idx_ff == RESP_LAST);

   // With a job queued, the output register refills when empty or being drained.
   assign advance  = job_valid && (!valid_ff || out_take);
   assign job_pop  = advance && at_last;

   always_comb begin
      if (idx_ff inside {[OFF_NAME_0:OFF_NAME_31]}) begin
         resp_byte = enc;
      end else begin
         case (idx_ff)
            6'd0:    resp_byte = job.query_id[15:8];
            6'd1:    resp_byte = job.query_id[7:0];
            6'd2:    resp_byte = RESP_FLAGS_HI;
            6'd3:    resp_byte = RESP_FLAGS_LO;
            6'd7:    resp_byte = 8'h01;
            6'd8:    resp_byte = job.authority_count[15:8];
            6'd9:    resp_byte = job.authority_count[7:0];
            6'd10:   resp_byte = job.additional_count[15:8];
            6'd11:   resp_byte = job.additional_count[7:0];
            6'd12:   resp_byte = LABEL_LEN;
            6'd47:   resp_byte = TYPE_NB;
            6'd49:   resp_byte = CLASS_IN;
            6'd53:   resp_byte = RESP_TTL;
            6'd55:   resp_byte = RESP_RDLEN;
            6'd58:   resp_byte = cfg.reply_ip[31:24];
            6'd59:   resp_byte = cfg.reply_ip[23:16];
            6'd60:   resp_byte = cfg.reply_ip[15:8];
            6'd61:   resp_byte = cfg.reply_ip[7:0];
            default: resp_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= resp_byte;
         last_ff <= at_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   `ASSERT_ALWAYS(a_idx_range, clock, reset, idx_ff <= RESP_LAST, "response index out of range")
   `ASSERT_IMPLIES(a_idx_job, clock, reset, idx_ff != 6'd0, job_valid, "response in flight without a job")

endmodule

FILE: rtl/netbios_name_query_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NetBIOS name query responder
// Parses NetBIOS name query requests and streams positive responses.
// ----------------------------------------------------------------------------
// Usage: the UDP payload of a received datagram enters one byte per beat on
// the req_ side (push/full); req_end_of_packet marks its last byte. When a
// query for the configured name passes every check, the 62-byte positive
// response leaves on the rsp_ side (empty/pop), rsp_reply_last on its final
// beat. Request bytes are taken one per cycle unless full. Passing queries
// wait in a job queue of JobDepth entries and then pass through the output
// register, which streams one byte per cycle while pop is held. The request
// side shows full only while that queue is full, so a stalled receiver
// eventually holds off the sender. The name and IP registers must be written
// through csr_ only while the block is idle; the block does not enforce
// this. Reset clears registers, parser state, job queue and output register.
// ----------------------------------------------------------------------------
module netbios_name_query_responder
   import nbns_pkg::*;
#(
   parameter int unsigned JobDepth = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_payload_byte,
   input  logic                req_end_of_packet,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_reply_byte,
   output logic                rsp_reply_last,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   nbns_cfg_type cfg_ff, cfg_in;
   nbns_job_type parsed_job;
   nbns_job_type head_job;
   logic         beat;
   logic         job_push;
   logic         job_full;
   logic         job_empty;
   logic         job_pop;
   logic         out_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NAME_LOW:  cfg_in.name_chars_low  = csr_wdata;
            CSR_NAME_HIGH: cfg_in.name_chars_high = csr_wdata[55:0];
            CSR_NAME_LEN:  cfg_in.name_length     = csr_wdata[3:0];
            CSR_REPLY_IP:  cfg_in.reply_ip        = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = job_full;
   assign beat     = req_push && !req_full;

   nbns_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .beat          (beat),
      .payload_byte  (req_payload_byte),
      .end_of_packet (req_end_of_packet),
      .job_push      (job_push),
      .job           (parsed_job)
   );

   nbns_job_fifo #(
      .Depth (JobDepth)
   ) u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (parsed_job),
      .full     (job_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (head_job)
   );

   nbns_reply_gen u_reply_gen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (!job_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .out_valid (out_valid),
      .out_byte  (rsp_reply_byte),
      .out_last  (rsp_reply_last),
      .out_take  (rsp_pop)
   );

   assign rsp_empty = !out_valid;

endmodule
